FILE: rtl/spc_pkg.sv
package spc_pkg;

    // Field and register widths.
    localparam int POS_W      = 16;
    localparam int LIM_W      = 16;
    localparam int MARGIN_W   = 15;
    localparam int SPEED_W    = 11;
    localparam int PER_W      = 4;
    localparam int MS_W       = 16;
    localparam int PCT_W      = 8;
    localparam int FUNC_W     = 3;
    localparam int JOG_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Window edges need 18 signed bits; two more keep clamping and stepping exact.
    localparam int WIN_W = 18;
    localparam int AW    = ((POS_W > WIN_W) ? POS_W : WIN_W) + 2;

    // Shared divider sizes.
    localparam int NUM_W = 24;
    localparam int DEN_W = SPEED_W;

    // Speed and scaling constants.
    localparam int SPEED_MIN_I = 80;
    localparam int SPEED_MAX_I = 1500;
    localparam int MS_PER_S_I  = 1000;
    localparam int PCT_FULL_I  = 100;

    localparam logic [SPEED_W-1:0] SPEED_MIN  = SPEED_W'(SPEED_MIN_I);
    localparam logic [SPEED_W-1:0] SPEED_MAX  = SPEED_W'(SPEED_MAX_I);
    localparam logic [SPEED_W-1:0] SPEED_SPAN = SPEED_W'(SPEED_MAX_I - SPEED_MIN_I);
    localparam logic [PCT_W-1:0]   PCT_FULL   = PCT_W'(PCT_FULL_I);
    localparam logic [NUM_W-1:0]   MS_PER_S   = NUM_W'(MS_PER_S_I);

    // Reset values of the registers.
    localparam int DEFAULT_SPEED_RESET_I = 500;
    localparam int SPEED_RESET_I = (DEFAULT_SPEED_RESET_I < SPEED_MIN_I) ? SPEED_MIN_I :
                                   ((DEFAULT_SPEED_RESET_I > SPEED_MAX_I) ? SPEED_MAX_I :
                                    DEFAULT_SPEED_RESET_I);
    localparam int PERIOD_RESET_I = ((MS_PER_S_I / SPEED_RESET_I) == 0) ? 1 :
                                    (MS_PER_S_I / SPEED_RESET_I);

    localparam logic signed [LIM_W-1:0] LOWER_RESET  = -LIM_W'(2000);
    localparam logic signed [LIM_W-1:0] UPPER_RESET  = LIM_W'(2000);
    localparam logic [MARGIN_W-1:0]     MARGIN_RESET = MARGIN_W'(100);
    localparam logic [SPEED_W-1:0]      SPEED_RESET  = SPEED_W'(SPEED_RESET_I);
    localparam logic [PER_W-1:0]        PERIOD_RESET = PER_W'(PERIOD_RESET_I);
    localparam logic                    SAVED_ZERO_RESET = 1'b0;

    // Position range in the extended width.
    localparam logic signed [AW-1:0] POS_MAX_X = {{(AW-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    localparam logic signed [AW-1:0] POS_MIN_X = ~POS_MAX_X;

    // Command codes.
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_JOG   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_OPEN  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ZERO  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_TRUST = 3'd5;

    // Jog directions.
    localparam logic [JOG_W-1:0] JOG_OPEN = 2'd1;
    localparam logic [JOG_W-1:0] JOG_HALT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO   = 3'd4;

    typedef enum logic [1:0] {
        MODE_UNHOMED = 2'd0,
        MODE_READY   = 2'd1,
        MODE_FAULT   = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLAMP,
        ST_STEP,
        ST_JOG_DIV,
        ST_JOG_WAIT,
        ST_PER_DIV,
        ST_PER_WAIT,
        ST_OPEN_DIV,
        ST_OPEN_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [MS_W-1:0]   tick_ms;
        logic [JOG_W-1:0]  jog_dir;
        logic [PCT_W-1:0]  percent;
    } spc_in_t;

    typedef struct packed {
        logic                    step_pulse;
        logic                    step_dir;
        logic                    drive_enable;
        logic [1:0]              mode;
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] target;
        logic                    zero_known;
        logic [SPEED_W-1:0]      run_speed;
        logic                    accepted;
    } spc_out_t;

    // Window edges and load strobes from the register bank.
    typedef struct packed {
        logic signed [AW-1:0] win_lo;
        logic signed [AW-1:0] win_hi;
        logic                 speed_load;
        logic [SPEED_W-1:0]   speed_val;
        logic                 zero_load;
        logic                 zero_val;
    } spc_cfg_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] y;
        begin
            if (x < POS_MIN_X) begin
                y = POS_MIN_X;
            end else if (x > POS_MAX_X) begin
                y = POS_MAX_X;
            end else begin
                y = x;
            end
            sat_pos = y[POS_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/spc_cfg.sv
module spc_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output spc_pkg::spc_cfg_t                   cfg
);

    logic signed [spc_pkg::LIM_W-1:0] lower_reg;
    logic signed [spc_pkg::LIM_W-1:0] upper_reg;
    logic [spc_pkg::MARGIN_W-1:0]     margin_reg;
    logic [spc_pkg::SPEED_W-1:0]      speed_clamped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg  <= spc_pkg::LOWER_RESET;
            upper_reg  <= spc_pkg::UPPER_RESET;
            margin_reg <= spc_pkg::MARGIN_RESET;
        end else if (cfg_we) begin
            if (cfg_index == spc_pkg::CFG_LOWER) begin
                lower_reg <= cfg_data[spc_pkg::LIM_W-1:0];
            end
            if (cfg_index == spc_pkg::CFG_UPPER) begin
                upper_reg <= cfg_data[spc_pkg::LIM_W-1:0];
            end
            if (cfg_index == spc_pkg::CFG_MARGIN) begin
                margin_reg <= cfg_data[spc_pkg::MARGIN_W-1:0];
            end
        end
    end

    always_comb begin
        if (cfg_data < spc_pkg::CFG_DATA_W'(spc_pkg::SPEED_MIN)) begin
            speed_clamped = spc_pkg::SPEED_MIN;
        end else if (cfg_data > spc_pkg::CFG_DATA_W'(spc_pkg::SPEED_MAX)) begin
            speed_clamped = spc_pkg::SPEED_MAX;
        end else begin
            speed_clamped = cfg_data[spc_pkg::SPEED_W-1:0];
        end
    end

    always_comb begin
        cfg.win_lo = {{(spc_pkg::AW-spc_pkg::LIM_W){lower_reg[spc_pkg::LIM_W-1]}}, lower_reg}
                   + {{(spc_pkg::AW-spc_pkg::MARGIN_W){1'b0}}, margin_reg};
        cfg.win_hi = {{(spc_pkg::AW-spc_pkg::LIM_W){upper_reg[spc_pkg::LIM_W-1]}}, upper_reg}
                   - {{(spc_pkg::AW-spc_pkg::MARGIN_W){1'b0}}, margin_reg};
        cfg.speed_load = cfg_we && (cfg_index == spc_pkg::CFG_SPEED);
        cfg.speed_val  = speed_clamped;
        cfg.zero_load  = cfg_we && (cfg_index == spc_pkg::CFG_ZERO);
        cfg.zero_val   = cfg_data[0];
    end

endmodule

FILE: rtl/spc_div.sv
module spc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [spc_pkg::NUM_W-1:0]    num,
    input  logic [spc_pkg::DEN_W-1:0]    den,
    output logic                         done,
    output logic [spc_pkg::NUM_W-1:0]    quot
);

    localparam int ITER   = spc_pkg::NUM_W / 2;
    localparam int CNT_W  = $clog2(ITER + 1);
    localparam int DW     = spc_pkg::DEN_W;
    localparam int NW     = spc_pkg::NUM_W;

    logic [DW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DW:0]   r_a, r_a_sub, r_b, r_b_sub;
    logic          ge_a, ge_b;
    logic [NW-1:0] q_a, q_b;

    // Two restoring steps per cycle; the numerator shifts out as quotient bits shift in.
    always_comb begin
        r_a     = {rem_reg, quo_reg[NW-1]};
        ge_a    = r_a >= {1'b0, den_reg};
        r_a_sub = ge_a ? (r_a - {1'b0, den_reg}) : r_a;
        q_a     = {quo_reg[NW-2:0], ge_a};
        r_b     = {r_a_sub[DW-1:0], q_a[NW-1]};
        ge_b    = r_b >= {1'b0, den_reg};
        r_b_sub = ge_b ? (r_b - {1'b0, den_reg}) : r_b;
        q_b     = {q_a[NW-2:0], ge_b};
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CNT_W'(ITER);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = r_b_sub[DW-1:0];
            quo_next = q_b;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

FILE: rtl/stepper_position_controller.sv
// Step/direction position controller for one stepper axis.
// Commands arrive on the s_ channel (valid/ready) as one spc_in_t each; every
// command yields exactly one status transaction of type spc_out_t on the m_
// channel. The block works on one command at a time and holds s_ready low
// from acceptance until its result has been placed in the output register.
// After acceptance, most commands go from EXEC straight to DONE; a tick that
// issues a step passes CLAMP and STEP on the way. Set-open-percent and jog wait
// on the shared radix-4 divider, which holds the sequencer for each division
// (one for open-percent scaling, two for jog: speed scaling and then the
// period).
// The next command can be taken once the sequencer has returned to idle,
// after the result is registered.
// A write to default_speed reloads the speed at once and, from idle or a period
// division, recomputes the step period, during which no command is accepted.
// The output register lets the next command be accepted while a result still
// waits; if the receiver stalls, the following result waits in its final
// state until the register frees. Nothing is lost or repeated.
// Reset (aresetn low at a clock edge) returns the configuration registers and
// the axis state to their defaults: unhomed, position and target zero, driver
// off, speed from the default speed.
module stepper_position_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  spc_pkg::spc_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output spc_pkg::spc_out_t                 m_data,
    input  logic                              cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = spc_pkg::AW;
    localparam int PW = spc_pkg::POS_W;

    spc_pkg::spc_cfg_t cfg;

    spc_pkg::state_t state_reg, state_next;
    spc_pkg::mode_t  mode_reg, mode_next;

    logic                          zero_reg, zero_next;
    logic signed [PW-1:0]          pos_reg, pos_next;
    logic signed [PW-1:0]          tgt_reg, tgt_next;
    logic [spc_pkg::MS_W-1:0]      accum_reg, accum_next;
    logic [spc_pkg::SPEED_W-1:0]   speed_reg, speed_next;
    logic [spc_pkg::PER_W-1:0]     period_reg, period_next;
    logic                          enable_reg, enable_next;
    logic                          dir_reg, dir_next;
    logic                          pulse_reg, pulse_next;
    logic                          acc_reg, acc_next;
    logic                          per_cfg_reg, per_cfg_next;
    logic                          m_valid_reg, m_valid_next;
    spc_pkg::spc_in_t              cmd_reg, cmd_next;
    logic [spc_pkg::NUM_W-1:0]     mul_reg, mul_next;
    spc_pkg::spc_out_t             m_data_reg, m_data_next;

    logic                          div_start;
    logic [spc_pkg::NUM_W-1:0]     div_num;
    logic [spc_pkg::DEN_W-1:0]     div_den;
    logic                          div_done;
    logic [spc_pkg::NUM_W-1:0]     div_quot;

    logic                          in_accept;
    logic                          out_free;
    logic                          is_ready;
    logic signed [AW-1:0]          pos_x, tgt_x, clamp_x, diff_x;
    logic [spc_pkg::MS_W-1:0]      accum_sum;
    logic                          period_hit;
    logic [6:0]                    jog_pct, frac_pct;
    logic [17:0]                   jog_prod;
    logic [spc_pkg::NUM_W-1:0]     open_prod;
    logic                          step_up;

    spc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // A speed reload takes the divider, so no command is taken in that cycle.
    assign s_ready   = (state_reg == spc_pkg::ST_IDLE) && !cfg.speed_load;
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign is_ready  = (mode_reg == spc_pkg::MODE_READY);

    // Operand preparation for the current command.
    always_comb begin
        pos_x = {{(AW-PW){pos_reg[PW-1]}}, pos_reg};
        tgt_x = {{(AW-PW){tgt_reg[PW-1]}}, tgt_reg};
        diff_x = cfg.win_hi - cfg.win_lo;
        accum_sum  = accum_reg + cmd_reg.tick_ms;
        period_hit = accum_sum >= {{(spc_pkg::MS_W-spc_pkg::PER_W){1'b0}}, period_reg};

        if (tgt_x < cfg.win_lo) begin
            clamp_x = cfg.win_lo;
        end else if (tgt_x > cfg.win_hi) begin
            clamp_x = cfg.win_hi;
        end else begin
            clamp_x = tgt_x;
        end

        if (cmd_reg.percent == '0) begin
            jog_pct = 7'd1;
        end else if (cmd_reg.percent > spc_pkg::PCT_FULL) begin
            jog_pct = spc_pkg::PCT_FULL[6:0];
        end else begin
            jog_pct = cmd_reg.percent[6:0];
        end

        if (cmd_reg.percent > spc_pkg::PCT_FULL) begin
            frac_pct = spc_pkg::PCT_FULL[6:0];
        end else begin
            frac_pct = cmd_reg.percent[6:0];
        end

        jog_prod  = 18'(jog_pct) * 18'(spc_pkg::SPEED_SPAN);
        // The window is never wider than 65535 points when it is not empty.
        open_prod = spc_pkg::NUM_W'(diff_x[16:0]) * spc_pkg::NUM_W'(frac_pct);
        step_up   = tgt_reg > pos_reg;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spc_pkg::ST_IDLE: begin
                if (cfg.speed_load) begin
                    state_next = spc_pkg::ST_PER_DIV;
                end else if (in_accept) begin
                    state_next = spc_pkg::ST_EXEC;
                end
            end
            spc_pkg::ST_EXEC: begin
                state_next = spc_pkg::ST_DONE;
                if (cmd_reg.func == spc_pkg::FUNC_TICK) begin
                    if (is_ready && (pos_reg != tgt_reg) && period_hit) begin
                        state_next = spc_pkg::ST_CLAMP;
                    end
                end else if (cmd_reg.func == spc_pkg::FUNC_JOG) begin
                    if (is_ready) begin
                        state_next = spc_pkg::ST_JOG_DIV;
                    end
                end else if (cmd_reg.func == spc_pkg::FUNC_OPEN) begin
                    if (is_ready && (cfg.win_hi > cfg.win_lo)) begin
                        state_next = spc_pkg::ST_OPEN_DIV;
                    end
                end
            end
            spc_pkg::ST_CLAMP:    state_next = spc_pkg::ST_STEP;
            spc_pkg::ST_STEP:     state_next = spc_pkg::ST_DONE;
            spc_pkg::ST_JOG_DIV:  state_next = spc_pkg::ST_JOG_WAIT;
            spc_pkg::ST_JOG_WAIT: begin
                if (div_done) begin
                    state_next = spc_pkg::ST_PER_DIV;
                end
            end
            spc_pkg::ST_PER_DIV: begin
                state_next = cfg.speed_load ? spc_pkg::ST_PER_DIV : spc_pkg::ST_PER_WAIT;
            end
            spc_pkg::ST_PER_WAIT: begin
                if (cfg.speed_load) begin
                    state_next = spc_pkg::ST_PER_DIV;
                end else if (div_done) begin
                    state_next = per_cfg_reg ? spc_pkg::ST_IDLE : spc_pkg::ST_DONE;
                end
            end
            spc_pkg::ST_OPEN_DIV: state_next = spc_pkg::ST_OPEN_WAIT;
            spc_pkg::ST_OPEN_WAIT: begin
                if (div_done) begin
                    state_next = spc_pkg::ST_DONE;
                end
            end
            spc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = spc_pkg::ST_IDLE;
                end
            end
            default: state_next = spc_pkg::ST_IDLE;
        endcase
    end

    // Divider operands.
    always_comb begin
        div_start = 1'b0;
        div_num   = mul_reg;
        div_den   = spc_pkg::DEN_W'(spc_pkg::PCT_FULL);
        unique case (state_reg)
            spc_pkg::ST_JOG_DIV,
            spc_pkg::ST_OPEN_DIV: begin
                div_start = 1'b1;
            end
            spc_pkg::ST_PER_DIV: begin
                div_start = 1'b1;
                div_num   = spc_pkg::MS_PER_S;
                div_den   = speed_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Datapath updates.
    always_comb begin
        mode_next    = mode_reg;
        zero_next    = zero_reg;
        pos_next     = pos_reg;
        tgt_next     = tgt_reg;
        accum_next   = accum_reg;
        speed_next   = speed_reg;
        period_next  = period_reg;
        enable_next  = enable_reg;
        dir_next     = dir_reg;
        pulse_next   = pulse_reg;
        acc_next     = acc_reg;
        per_cfg_next = per_cfg_reg;
        cmd_next     = cmd_reg;
        mul_next     = mul_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (cfg.speed_load) begin
            speed_next = cfg.speed_val;
        end
        if (cfg.zero_load) begin
            zero_next = cfg.zero_val;
        end

        unique case (state_reg)
            spc_pkg::ST_IDLE: begin
                if (cfg.speed_load) begin
                    per_cfg_next = 1'b1;
                end else if (in_accept) begin
                    cmd_next   = s_data;
                    pulse_next = 1'b0;
                    acc_next   = 1'b0;
                end
            end
            spc_pkg::ST_EXEC: begin
                if (cmd_reg.func == spc_pkg::FUNC_TICK) begin
                    if (is_ready) begin
                        if (pos_reg == tgt_reg) begin
                            enable_next = 1'b0;
                        end else if (period_hit) begin
                            accum_next = '0;
                        end else begin
                            accum_next = accum_sum;
                        end
                    end
                end else if (cmd_reg.func == spc_pkg::FUNC_JOG) begin
                    if (is_ready) begin
                        mul_next     = spc_pkg::NUM_W'(jog_prod);
                        per_cfg_next = 1'b0;
                        if (cmd_reg.jog_dir == spc_pkg::JOG_HALT) begin
                            tgt_next    = pos_reg;
                            enable_next = 1'b0;
                        end else if (cmd_reg.jog_dir == spc_pkg::JOG_OPEN) begin
                            tgt_next = spc_pkg::sat_pos(cfg.win_hi);
                        end else begin
                            tgt_next = spc_pkg::sat_pos(cfg.win_lo);
                        end
                    end
                end else if (cmd_reg.func == spc_pkg::FUNC_STOP) begin
                    tgt_next    = pos_reg;
                    enable_next = 1'b0;
                end else if (cmd_reg.func == spc_pkg::FUNC_OPEN) begin
                    if (is_ready) begin
                        if (cfg.win_hi <= cfg.win_lo) begin
                            mode_next = spc_pkg::MODE_FAULT;
                        end else begin
                            mul_next = open_prod;
                        end
                    end
                end else if (cmd_reg.func == spc_pkg::FUNC_ZERO) begin
                    pos_next    = '0;
                    tgt_next    = '0;
                    zero_next   = 1'b1;
                    mode_next   = spc_pkg::MODE_READY;
                    enable_next = 1'b0;
                    acc_next    = 1'b1;
                end else if (cmd_reg.func == spc_pkg::FUNC_TRUST) begin
                    if (zero_reg) begin
                        pos_next  = '0;
                        tgt_next  = '0;
                        mode_next = spc_pkg::MODE_READY;
                        acc_next  = 1'b1;
                    end
                end
            end
            spc_pkg::ST_CLAMP: begin
                tgt_next = spc_pkg::sat_pos(clamp_x);
            end
            spc_pkg::ST_STEP: begin
                dir_next    = step_up;
                enable_next = 1'b1;
                pulse_next  = 1'b1;
                pos_next    = spc_pkg::sat_pos(step_up ? (pos_x + AW'(1)) : (pos_x - AW'(1)));
            end
            spc_pkg::ST_JOG_WAIT: begin
                // The scaled speed stays within the limits, so no clamp is needed.
                if (div_done) begin
                    speed_next = spc_pkg::SPEED_MIN + div_quot[spc_pkg::SPEED_W-1:0];
                end
            end
            spc_pkg::ST_PER_WAIT: begin
                if (div_done && !cfg.speed_load) begin
                    if (div_quot == '0) begin
                        period_next = spc_pkg::PER_W'(1);
                    end else begin
                        period_next = div_quot[spc_pkg::PER_W-1:0];
                    end
                end
            end
            spc_pkg::ST_OPEN_WAIT: begin
                if (div_done) begin
                    tgt_next = spc_pkg::sat_pos(cfg.win_lo
                                                + {{(AW-16){1'b0}}, div_quot[15:0]});
                end
            end
            spc_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.step_pulse   = pulse_reg;
                    m_data_next.step_dir     = dir_reg;
                    m_data_next.drive_enable = enable_reg;
                    m_data_next.mode         = mode_reg;
                    m_data_next.position     = pos_reg;
                    m_data_next.target       = tgt_reg;
                    m_data_next.zero_known   = zero_reg;
                    m_data_next.run_speed    = speed_reg;
                    m_data_next.accepted     = acc_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spc_pkg::ST_IDLE;
            mode_reg    <= spc_pkg::MODE_UNHOMED;
            zero_reg    <= spc_pkg::SAVED_ZERO_RESET;
            pos_reg     <= '0;
            tgt_reg     <= '0;
            accum_reg   <= '0;
            speed_reg   <= spc_pkg::SPEED_RESET;
            period_reg  <= spc_pkg::PERIOD_RESET;
            enable_reg  <= 1'b0;
            dir_reg     <= 1'b0;
            pulse_reg   <= 1'b0;
            acc_reg     <= 1'b0;
            per_cfg_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            zero_reg    <= zero_next;
            pos_reg     <= pos_next;
            tgt_reg     <= tgt_next;
            accum_reg   <= accum_next;
            speed_reg   <= speed_next;
            period_reg  <= period_next;
            enable_reg  <= enable_next;
            dir_reg     <= dir_next;
            pulse_reg   <= pulse_next;
            acc_reg     <= acc_next;
            per_cfg_reg <= per_cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        mul_reg    <= mul_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
